// ===== design/keyboard_event_fifo_core_macros.svh =====
// ----------------------------------------------------------------------------
// keyboard event fifo assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_EVENT_FIFO_CORE_MACROS_SVH
`define KEYBOARD_EVENT_FIFO_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kef assertion failed");

// next-cycle implication, disabled in reset
`define KEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kef assertion failed");

`endif

// ===== design/kef_pkg.sv =====
// ----------------------------------------------------------------------------
// kef_pkg
// types and constants shared by the keyboard event fifo modules
// ----------------------------------------------------------------------------
`default_nettype none

package kef_pkg;

    localparam int DEPTH_DEFAULT = 10;
    localparam int CODE_W        = 8;
    localparam int EVENT_W       = 9;
    localparam int SCAN_W        = 17;
    localparam int ACTION_W      = 2;
    localparam int COUNT_OUT_W   = 4;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    // register index, taken from paddr word bit 2
    localparam logic REG_IRQ_EN = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_KEY   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_DEQ   = 2'd2
    } action_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

`default_nettype wire

// ===== design/kef_cfg.sv =====
// ----------------------------------------------------------------------------
// kef_cfg
// apb register port holding the interrupt enable
// ----------------------------------------------------------------------------
`default_nettype none

module kef_cfg
    import kef_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic                       irq_en
);

    logic irq_en_reg;
    logic irq_en_next;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_IRQ_EN);

    always_comb
    begin
        irq_en_next = irq_en_reg;
        if (wr_hit)
        begin
            irq_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_en_reg <= 1'b0;
        end
        else
        begin
            irq_en_reg <= irq_en_next;
        end
    end

    // addresses beyond the register read as zero
    assign prdata = (paddr[2] == REG_IRQ_EN) ? {{(APB_DATA_W-1){1'b0}}, irq_en_reg}
                                             : '0;
    assign irq_en = irq_en_reg;

endmodule

`default_nettype wire

// ===== design/kef_ring.sv =====
// ----------------------------------------------------------------------------
// kef_ring
// pending event ring with registered head entry
// ----------------------------------------------------------------------------
`default_nettype none

module kef_ring
    import kef_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire ring_cmd_t                      cmd,
    input  wire logic      [EVENT_W-1:0]        wr_data,
    output logic           [EVENT_W-1:0]        head,
    output logic           [$clog2(DEPTH+1)-1:0] count,
    output ring_stat_t                          stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [EVENT_W-1:0] mem [DEPTH];
    logic [EVENT_W-1:0] head_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // prefetch the next oldest entry; bypass a push into an empty ring
    always_ff @(posedge clk)
    begin
        if (cmd.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wr_data;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    assign head       = head_reg;
    assign count      = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ===== design/keyboard_event_fifo_core.sv =====
// a transaction goes through the input register, then shows its result with done
// throughput: one transaction per cycle; busy never rises and the receiver cannot stall
// rate set by the single update pass between the input register and the state registers
// reset: flags, pointers, count and scan register clear at once; ring contents are
// undefined until written and are only read once counted
// ----------------------------------------------------------------------------
// keyboard_event_fifo_core
// keyboard scan register, ready flag and ring of pending key events
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_event_fifo_core
    import kef_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command side
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [ACTION_W-1:0]    action,
    input  wire logic [CODE_W-1:0]      key_code,
    input  wire logic                   key_down,
    // result side
    output logic                        done,
    output logic      [SCAN_W-1:0]      scan_word,
    output logic                        ready_res,
    output logic                        irq_pulse,
    output logic      [COUNT_OUT_W-1:0] pending_count,
    output logic                        dropped,
    // register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    // input stage
    logic                stage_vld_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                down_reg;

    // architectural state, which doubles as the result register
    logic [SCAN_W-1:0]   scan_reg;
    logic [SCAN_W-1:0]   scan_next;
    logic                ready_reg;
    logic                ready_next;
    logic                done_reg;
    logic                irq_reg;
    logic                irq_next;
    logic                drop_reg;
    logic                drop_next;

    logic                irq_en;
    logic [EVENT_W-1:0]  kbd_evt;
    logic [EVENT_W-1:0]  ring_head;
    logic [CNT_W-1:0]    ring_count;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
    ring_cmd_t           ring_cmd;
    ring_stat_t          ring_stat;

    // no multi-cycle work, so the block never refuses a transaction
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= start;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            action_reg <= action;
            code_reg   <= key_code;
            down_reg   <= key_down;
        end
    end

    // release events carry bit 8
    assign kbd_evt = {~down_reg, code_reg};

    // single update pass for the staged transaction
    always_comb
    begin
        scan_next    = scan_reg;
        ready_next   = ready_reg;
        irq_next     = 1'b0;
        drop_next    = 1'b0;
        ring_cmd     = '0;
        if (stage_vld_reg)
        begin
            case (action_reg)
                ACT_KEY:
                begin
                    if (ready_reg)
                    begin
                        // queue behind the unread word, or lose it when full
                        if (ring_stat.full)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            ring_cmd.push = 1'b1;
                        end
                    end
                    else
                    begin
                        scan_next  = {1'b1, {(SCAN_W-EVENT_W-1){1'b0}}, kbd_evt};
                        ready_next = irq_en;
                        irq_next   = irq_en;
                    end
                end
                ACT_CLEAR:
                begin
                    ready_next = 1'b0;
                end
                ACT_DEQ:
                begin
                    // only moves an event when the scan word has been read
                    if (!ready_reg && !ring_stat.empty)
                    begin
                        ring_cmd.pop = 1'b1;
                        scan_next    = {1'b1, {(SCAN_W-EVENT_W-1){1'b0}}, ring_head};
                        ready_next   = irq_en;
                        irq_next     = irq_en;
                    end
                end
                default:
                begin
                    // unused action code leaves the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg  <= '0;
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
            irq_reg   <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            scan_reg  <= scan_next;
            ready_reg <= ready_next;
            done_reg  <= stage_vld_reg;
            irq_reg   <= irq_next;
            drop_reg  <= drop_next;
        end
    end

    kef_ring #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ring_cmd),
        .wr_data (kbd_evt),
        .head    (ring_head),
        .count   (ring_count),
        .stat    (ring_stat)
    );

    kef_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .irq_en  (irq_en)
    );

    // state registers update at the same edge as done, so they are the result
    assign count_ext     = (CNT_W+COUNT_OUT_W)'(ring_count);
    assign done          = done_reg;
    assign scan_word     = scan_reg;
    assign ready_res     = ready_reg;
    assign irq_pulse     = irq_reg;
    assign pending_count = count_ext[COUNT_OUT_W-1:0];
    assign dropped       = drop_reg;

endmodule

`default_nettype wire

// ===== design/kef_checker.sv =====
// ----------------------------------------------------------------------------
// kef_checker
// port-level checks on the keyboard event fifo, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyboard_event_fifo_core_macros.svh"

module kef_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [16:0] scan_word,
    input wire logic        ready_res,
    input wire logic        irq_pulse,
    input wire logic        dropped
);

    logic accepted;

    assign accepted = start && !busy;

    // every accepted transaction gives exactly one result, in order
    `KEF_ASSERT_NXT(a_accept_gives_result, clk, rst_n, accepted, ##1 done)
    `KEF_ASSERT_NXT(a_no_spurious_result, clk, rst_n, !accepted, ##1 !done)
    // an event is only lost while the scan word is still unread
    `KEF_ASSERT_IMP(a_drop_while_ready, clk, rst_n, done && dropped, ready_res && !irq_pulse)
    // an interrupt always comes with a fresh valid scan word
    `KEF_ASSERT_IMP(a_irq_valid_word, clk, rst_n, done && irq_pulse, ready_res && scan_word[16])

endmodule

bind keyboard_event_fifo_core kef_checker u_kef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .scan_word (scan_word),
    .ready_res (ready_res),
    .irq_pulse (irq_pulse),
    .dropped   (dropped)
);

`default_nettype wire

// ===== test/tb_keyboard_event_fifo_core.sv =====
// ----------------------------------------------------------------------------
// tb_keyboard_event_fifo_core
// self-checking bench: command transactions are predicted by a cycle-free
// model of the scan register, ready flag and event ring, and every result
// strobe is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_keyboard_event_fifo_core;
    import kef_pkg::*;

    // action code the block does not define; it must leave the state alone
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RING_DEPTH  = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 100000;
    localparam int REPORT_MAX  = 10;

    // one command transaction as the sender presents it
    typedef struct packed {
        logic [ACTION_W-1:0] op;
        logic [CODE_W-1:0]   code;
        logic                down;
    } kbd_cmd_t;

    // one result transaction as it appears on the result ports
    typedef struct packed {
        logic [SCAN_W-1:0]      word;
        logic                   ready;
        logic                   irq;
        logic [COUNT_OUT_W-1:0] count;
        logic                   drop;
    } scan_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // command side, all inputs known from time zero
    logic                   start    = 1'b0;
    logic                   busy;
    logic [ACTION_W-1:0]    action   = '0;
    logic [CODE_W-1:0]      key_code = '0;
    logic                   key_down = 1'b0;

    // result side
    logic                   done;
    logic [SCAN_W-1:0]      scan_word;
    logic                   ready_res;
    logic                   irq_pulse;
    logic [COUNT_OUT_W-1:0] pending_count;
    logic                   dropped;

    // register port
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr   = '0;
    logic [APB_DATA_W-1:0]  pwdata  = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // stimulus backlog and predicted results still in flight
    kbd_cmd_t     cmd_backlog[$];
    scan_result_t scan_expect_q[$];
    kbd_cmd_t     cmd_on_port;
    logic         no_idle = 1'b0;

    // shadow of the block state used for prediction
    logic                   irq_en_m;
    logic [SCAN_W-1:0]      scan_m;
    logic                   ready_m;
    logic [EVENT_W-1:0]     ring_m[RING_DEPTH];
    int                     wr_m;
    int                     rd_m;
    int                     fill_m;

    // bookkeeping
    int err_count   = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_drops     = 0;
    int n_ring_load = 0;
    int n_irqs      = 0;
    int cycles      = 0;

    keyboard_event_fifo_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .key_code      (key_code),
        .key_down      (key_down),
        .done          (done),
        .scan_word     (scan_word),
        .ready_res     (ready_res),
        .irq_pulse     (irq_pulse),
        .pending_count (pending_count),
        .dropped       (dropped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: apply one accepted transaction to the shadow state and
    // return what the block should report for it
    // ------------------------------------------------------------------
    function automatic scan_result_t next_scan_state(kbd_cmd_t c);
        scan_result_t       r;
        logic [EVENT_W-1:0] ev;
        logic               load;
        r    = '0;
        ev   = '0;
        load = 1'b0;
        case (c.op)
            ACT_KEY:
            begin
                // release events carry bit 8
                ev = {~c.down, c.code};
                if (!ready_m)
                    load = 1'b1;
                else if (fill_m < RING_DEPTH)
                begin
                    ring_m[wr_m] = ev;
                    wr_m   = (wr_m == RING_DEPTH - 1) ? 0 : wr_m + 1;
                    fill_m = fill_m + 1;
                end
                else
                begin
                    // ring full while software has not read the last key
                    r.drop  = 1'b1;
                    n_drops = n_drops + 1;
                end
            end
            ACT_CLEAR:
                ready_m = 1'b0;
            ACT_DEQ:
            begin
                // only when software has read the scan word and something waits
                if (!ready_m && fill_m > 0)
                begin
                    ev     = ring_m[rd_m];
                    rd_m   = (rd_m == RING_DEPTH - 1) ? 0 : rd_m + 1;
                    fill_m = fill_m - 1;
                    load   = 1'b1;
                    n_ring_load = n_ring_load + 1;
                end
            end
            default:
                ;
        endcase
        if (load)
        begin
            scan_m = {1'b1, {(SCAN_W - EVENT_W - 1){1'b0}}, ev};
            // with interrupts off the word is loaded but ready stays low
            if (irq_en_m)
            begin
                ready_m = 1'b1;
                r.irq   = 1'b1;
                n_irqs  = n_irqs + 1;
            end
        end
        r.word  = scan_m;
        r.ready = ready_m;
        r.count = fill_m[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_cmd(input logic [ACTION_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic down);
        kbd_cmd_t c;
        c.op   = op;
        c.code = code;
        c.down = down;
        cmd_backlog.push_back(c);
    endtask

    task automatic add_random_key();
        add_cmd(ACT_KEY, $urandom_range(0, 255), $urandom_range(0, 1));
    endtask

    // mostly plausible keyboard traffic: key bursts that fill the ring,
    // software reads (clear then dequeue), plus stray and unused commands
    task automatic queue_random(input int n);
        int left;
        int r;
        int burst;
        left = n;
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                burst = $urandom_range(6, 13);
                repeat (burst) add_random_key();
                left = left - burst;
            end
            else if (r < 50)
            begin
                add_random_key();
                left = left - 1;
            end
            else if (r < 66)
            begin
                add_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1));
                left = left - 1;
            end
            else if (r < 84)
            begin
                add_cmd(ACT_DEQ, $urandom_range(0, 255), $urandom_range(0, 1));
                left = left - 1;
            end
            else if (r < 96)
            begin
                add_cmd(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1));
                add_cmd(ACT_DEQ, $urandom_range(0, 255), $urandom_range(0, 1));
                left = left - 2;
            end
            else
            begin
                add_cmd(ACT_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
                left = left - 1;
            end
        end
    endtask

    // hold the sender off until the backlog is sent and every result is back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || start || scan_expect_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // two-phase register write; only called while the block is idle
    task automatic write_irq_enable(input logic en);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IRQ_EN, 2'b00};
        pwdata  <= {{(APB_DATA_W - 1){1'b0}}, en};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        irq_en_m  = en;
    endtask

    // ------------------------------------------------------------------
    // driver: retires the transaction on the port when the block takes it,
    // predicts its result, then presents the next one or idles at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_cmd
        kbd_cmd_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                scan_expect_q.push_back(next_scan_state(cmd_on_port));
                n_accepted = n_accepted + 1;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= 9))
                begin
                    nxt         = cmd_backlog.pop_front();
                    cmd_on_port = nxt;
                    start    <= 1'b1;
                    action   <= nxt.op;
                    key_code <= nxt.code;
                    key_down <= nxt.down;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_count = err_count + 1;
        if (err_count <= REPORT_MAX)
            $display("mismatch on %s: expected %0h, got %0h (result %0d)",
                     what, want, got, n_results);
    endtask

    // ------------------------------------------------------------------
    // monitor: every done strobe is one result transaction; the receiver
    // cannot stall, so each is checked in the cycle it appears
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_scan
        scan_result_t want;
        if (rst_n && done)
        begin
            n_results = n_results + 1;
            if (scan_expect_q.size() == 0)
                flag_mismatch("unexpected result, scan_word", '0, scan_word);
            else
            begin
                want = scan_expect_q.pop_front();
                if (scan_word !== want.word)
                    flag_mismatch("scan_word", want.word, scan_word);
                if (ready_res !== want.ready)
                    flag_mismatch("ready_res", want.ready, ready_res);
                if (irq_pulse !== want.irq)
                    flag_mismatch("irq_pulse", want.irq, irq_pulse);
                if (pending_count !== want.count)
                    flag_mismatch("pending_count", want.count, pending_count);
                if (dropped !== want.drop)
                    flag_mismatch("dropped", want.drop, dropped);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, scan_expect_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        irq_en_m = 1'b0;
        scan_m   = '0;
        ready_m  = 1'b0;
        wr_m     = 0;
        rd_m     = 0;
        fill_m   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // interrupts off: keys load the scan word but never raise ready
        add_cmd(ACT_KEY, 8'h00, 1'b1);
        add_cmd(ACT_KEY, 8'hff, 1'b0);
        add_cmd(ACT_DEQ, 8'h00, 1'b0);      // empty ring, nothing to move
        add_cmd(ACT_CLEAR, 8'hff, 1'b1);
        add_cmd(ACT_UNUSED, 8'h5a, 1'b1);   // undefined action leaves state alone
        add_cmd(ACT_KEY, 8'h5a, 1'b1);
        wait_drained();

        // interrupts on: first key raises ready, the rest fill the ring
        write_irq_enable(1'b1);
        add_cmd(ACT_KEY, 8'h12, 1'b1);
        for (int i = 0; i < RING_DEPTH; i++)
            add_cmd(ACT_KEY, (i == 0) ? 8'hff : (i == 1) ? 8'h00 : 8'h30 + i, i[0]);
        add_cmd(ACT_KEY, 8'ha5, 1'b0);      // ring full, this one is lost
        add_cmd(ACT_DEQ, 8'h00, 1'b0);      // still ready, dequeue does nothing
        add_cmd(ACT_CLEAR, 8'h00, 1'b0);
        add_cmd(ACT_DEQ, 8'h00, 1'b0);      // oldest queued event reaches the scan word
        add_cmd(ACT_UNUSED, 8'h00, 1'b0);
        wait_drained();

        // random traffic with interrupts on
        queue_random(230);
        wait_drained();

        // interrupts off: leftover ring entries drain without raising ready
        write_irq_enable(1'b0);
        queue_random(120);
        wait_drained();

        // back on, back-to-back transactions with no sender gaps
        write_irq_enable(1'b1);
        no_idle = 1'b1;
        queue_random(150);
        wait_drained();
        no_idle = 1'b0;

        queue_random(100);
        wait_drained();

        $display("covered %0d transactions, %0d results: %0d ring loads, %0d interrupts,",
                 n_accepted, n_results, n_ring_load, n_irqs);
        $display("%0d dropped keys, interrupt enable toggled on and off", n_drops);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
